[rtl/core/escalating_pulse_watchdog_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the escalating pulse watchdog
// Define NO_ASSERTIONS to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef ESCALATING_PULSE_WATCHDOG_MACROS_SVH
`define ESCALATING_PULSE_WATCHDOG_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define EPW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds at every edge outside reset.
`define EPW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`else

`define EPW_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define EPW_ASSERT_ALWAYS(label, clk, rst, cond, msg)

`endif

`endif

[rtl/core/epw_pkg.sv]
// ---------------------------------------------------------------------------
// epw_pkg
// Shared types, codes and register reset values of the pulse watchdog.
// ---------------------------------------------------------------------------
`default_nettype none

package epw_pkg;

   localparam int unsigned NUM_REGS   = 7;
   localparam int unsigned NUM_THRESH = 3;
   localparam int unsigned CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_LOST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_BEEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_BEEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONTINUOUS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_ONE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_TWO   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_THREE = 3'd6;

   // Register reset values
   localparam logic [31:0] RST_PULSE_LOST  = 32'd2000;
   localparam logic [31:0] RST_SHORT_BEEP  = 32'd60000;
   localparam logic [31:0] RST_LONG_BEEP   = 32'd120000;
   localparam logic [31:0] RST_CONTINUOUS  = 32'd300000;
   localparam logic [31:0] RST_RESET_ONE   = 32'd600000;
   localparam logic [31:0] RST_RESET_TWO   = 32'd900000;
   localparam logic [31:0] RST_RESET_THREE = 32'd1200000;

   // LED codes
   localparam logic [1:0] LED_BOOT = 2'd0;
   localparam logic [1:0] LED_OK   = 2'd1;
   localparam logic [1:0] LED_LOST = 2'd2;

   // Buzzer stages
   localparam logic [1:0] BUZZ_SILENT     = 2'd0;
   localparam logic [1:0] BUZZ_SHORT      = 2'd1;
   localparam logic [1:0] BUZZ_LONG       = 2'd2;
   localparam logic [1:0] BUZZ_CONTINUOUS = 2'd3;

   typedef struct packed {
      logic [31:0] pulse_lost_ms;
      logic [31:0] short_beep_ms;
      logic [31:0] long_beep_ms;
      logic [31:0] continuous_ms;
      logic [31:0] reset_one_ms;
      logic [31:0] reset_two_ms;
      logic [31:0] reset_three_ms;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/core/epw_if.sv]
// ---------------------------------------------------------------------------
// epw_if
// Request, response and register-write channels of the pulse watchdog.
// ---------------------------------------------------------------------------
`default_nettype none

interface epw_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        pulse_seen;
   logic        mute_press;

   modport source (output valid, output now_ms, output pulse_seen, output mute_press,
                   input ready);
   modport sink   (input valid, input now_ms, input pulse_seen, input mute_press,
                   output ready);
endinterface

interface epw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] led_status;
   logic [1:0] buzzer_level;
   logic       mute_latched;
   logic       reset_fire;
   logic [1:0] attempts_used;

   modport source (output valid, output led_status, output buzzer_level,
                   output mute_latched, output reset_fire, output attempts_used,
                   input ready);
   modport sink   (input valid, input led_status, input buzzer_level,
                   input mute_latched, input reset_fire, input attempts_used,
                   output ready);
endinterface

interface epw_csr_if;
   logic                           valid;
   logic                           ready;
   logic [epw_pkg::CSR_IDX_W-1:0]  index;
   logic [31:0]                    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/epw_csr.sv]
// ---------------------------------------------------------------------------
// epw_csr
// Threshold register file; writes beyond the last register are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module epw_csr (
   input  wire            clock,
   input  wire            reset,
   epw_csr_if.sink        csr,
   output epw_pkg::cfg_type cfg
);

   epw_pkg::cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_lost_ms  <= epw_pkg::RST_PULSE_LOST;
         cfg_ff.short_beep_ms  <= epw_pkg::RST_SHORT_BEEP;
         cfg_ff.long_beep_ms   <= epw_pkg::RST_LONG_BEEP;
         cfg_ff.continuous_ms  <= epw_pkg::RST_CONTINUOUS;
         cfg_ff.reset_one_ms   <= epw_pkg::RST_RESET_ONE;
         cfg_ff.reset_two_ms   <= epw_pkg::RST_RESET_TWO;
         cfg_ff.reset_three_ms <= epw_pkg::RST_RESET_THREE;
      end else if (csr.valid) begin
         unique case (csr.index)
            epw_pkg::REG_PULSE_LOST:  cfg_ff.pulse_lost_ms  <= csr.data;
            epw_pkg::REG_SHORT_BEEP:  cfg_ff.short_beep_ms  <= csr.data;
            epw_pkg::REG_LONG_BEEP:   cfg_ff.long_beep_ms   <= csr.data;
            epw_pkg::REG_CONTINUOUS:  cfg_ff.continuous_ms  <= csr.data;
            epw_pkg::REG_RESET_ONE:   cfg_ff.reset_one_ms   <= csr.data;
            epw_pkg::REG_RESET_TWO:   cfg_ff.reset_two_ms   <= csr.data;
            epw_pkg::REG_RESET_THREE: cfg_ff.reset_three_ms <= csr.data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/epw_engine.sv]
// ---------------------------------------------------------------------------
// epw_engine
// Input register, watchdog state, evaluation logic and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module epw_engine #(
   parameter int unsigned MAX_ATTEMPTS = 3
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire epw_pkg::cfg_type cfg,
   epw_req_if.sink               req,
   epw_rsp_if.source             rsp
);

   // Input stage
   logic        s1_valid_ff;
   logic [31:0] s1_now_ff;
   logic        s1_pulse_ff;
   logic        s1_mute_ff;

   // Watchdog state
   logic        ever_ff;
   logic [31:0] last_ff;
   logic        mute_ff;
   logic [1:0]  count_ff;

   // Result register
   logic        out_valid_ff;
   logic [1:0]  out_led_ff;
   logic [1:0]  out_buzz_ff;
   logic        out_mute_ff;
   logic        out_fire_ff;
   logic [1:0]  out_count_ff;

   // Next state and result
   logic        ever_in;
   logic [31:0] last_in;
   logic        mute_in;
   logic [1:0]  count_in;
   logic [1:0]  led_in;
   logic [1:0]  buzz_in;
   logic        fire_in;

   logic [1:0]  count_base;
   logic [31:0] elapsed;
   logic [31:0] reset_thresh;
   logic        advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;

   always_comb begin
      // A pulse in this request takes effect before the evaluation.
      ever_in    = ever_ff | s1_pulse_ff;
      last_in    = s1_pulse_ff ? s1_now_ff : last_ff;
      count_base = s1_pulse_ff ? 2'd0 : count_ff;
      mute_in    = (mute_ff & !s1_pulse_ff) | s1_mute_ff;
      elapsed    = s1_now_ff - last_in;

      case (count_base)
         2'd0:    reset_thresh = cfg.reset_one_ms;
         2'd1:    reset_thresh = cfg.reset_two_ms;
         default: reset_thresh = cfg.reset_three_ms;
      endcase

      led_in   = epw_pkg::LED_BOOT;
      buzz_in  = epw_pkg::BUZZ_SILENT;
      fire_in  = 1'b0;
      count_in = count_base;

      if (ever_in) begin
         if (elapsed < cfg.pulse_lost_ms) begin
            led_in = epw_pkg::LED_OK;
         end else begin
            led_in = epw_pkg::LED_LOST;
            if (elapsed >= cfg.continuous_ms) begin
               buzz_in = epw_pkg::BUZZ_CONTINUOUS;
            end else if (elapsed >= cfg.long_beep_ms) begin
               buzz_in = epw_pkg::BUZZ_LONG;
            end else if (elapsed >= cfg.short_beep_ms) begin
               buzz_in = epw_pkg::BUZZ_SHORT;
            end
            if ((count_base < 2'(MAX_ATTEMPTS)) &&
                (count_base < 2'(epw_pkg::NUM_THRESH)) &&
                (elapsed >= reset_thresh)) begin
               fire_in  = 1'b1;
               count_in = count_base + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ever_ff      <= 1'b0;
         last_ff      <= 32'd0;
         mute_ff      <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (req.valid && req.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               ever_ff  <= ever_in;
               last_ff  <= last_in;
               mute_ff  <= mute_in;
               count_ff <= count_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_now_ff   <= req.now_ms;
         s1_pulse_ff <= req.pulse_seen;
         s1_mute_ff  <= req.mute_press;
      end
      if (advance && s1_valid_ff) begin
         out_led_ff   <= led_in;
         out_buzz_ff  <= buzz_in;
         out_mute_ff  <= mute_in;
         out_fire_ff  <= fire_in;
         out_count_ff <= count_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.led_status    = out_led_ff;
   assign rsp.buzzer_level  = out_buzz_ff;
   assign rsp.mute_latched  = out_mute_ff;
   assign rsp.reset_fire    = out_fire_ff;
   assign rsp.attempts_used = out_count_ff;

endmodule

`default_nettype wire

[rtl/core/escalating_pulse_watchdog.sv]
// ---------------------------------------------------------------------------
// escalating_pulse_watchdog
// Heartbeat watchdog with escalating buzzer stages and a forced-reset
// schedule.
//
// Usage:
//   req  - one request per tick: now_ms, pulse_seen, mute_press.
//   rsp  - one response per request: led_status, buzzer_level,
//          mute_latched, reset_fire, attempts_used, in request order.
//   csr  - register writes (index 0..6, data 32 bits); always ready,
//          out-of-range indexes are dropped. Write only while idle.
// Pipeline: an accepted request passes through the input register, then the
//   result register, which drives its response.
// Throughput: one request per cycle unless rsp is held; the evaluation is
//   one subtract and a handful of 32-bit compares between the two registers.
// Reset: thresholds return to their defaults, the block returns to
//   booting with mute cleared and no attempts, both stages empty.
// Stall: while rsp is held, the result register holds its response and the
//   input register still takes one more request before req.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "escalating_pulse_watchdog_macros.svh"

module escalating_pulse_watchdog #(
   parameter int unsigned MAX_ATTEMPTS = 3
) (
   input wire        clock,
   input wire        reset,
   epw_req_if.sink   req,
   epw_rsp_if.source rsp,
   epw_csr_if.sink   csr
);

   epw_pkg::cfg_type cfg;

   // Threshold registers
   epw_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // Evaluate each request against the held pulse state
   epw_engine #(
      .MAX_ATTEMPTS (MAX_ATTEMPTS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

   // A fired reset always counts as an attempt.
   `EPW_ASSERT_IMPL(a_fire_counts, clock, reset, rsp.valid && rsp.reset_fire, rsp.attempts_used != 2'd0, "reset fired with no attempt counted")
   // Booting reports silence and never fires.
   `EPW_ASSERT_IMPL(a_boot_quiet, clock, reset, rsp.valid && (rsp.led_status == epw_pkg::LED_BOOT), (rsp.buzzer_level == epw_pkg::BUZZ_SILENT) && !rsp.reset_fire, "booting response not quiet")
   // A live pulse keeps the alarm off.
   `EPW_ASSERT_IMPL(a_ok_quiet, clock, reset, rsp.valid && (rsp.led_status == epw_pkg::LED_OK), (rsp.buzzer_level == epw_pkg::BUZZ_SILENT) && !rsp.reset_fire, "pulse ok response not quiet")
   // The attempt count never passes the schedule length.
   `EPW_ASSERT_IMPL(a_count_bound, clock, reset, rsp.valid, rsp.attempts_used <= 2'(MAX_ATTEMPTS), "attempt count beyond schedule")

endmodule

`default_nettype wire

[sim/epw_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pulse watchdog scoreboard
// Tracks the watchdog state and thresholds on the testbench side, predicts
// one response per accepted request and checks responses in order.
// ---------------------------------------------------------------------------
package epw_scoreboard_pkg;

   localparam int unsigned ATTEMPT_LIMIT = 3;

   typedef struct packed {
      logic [1:0] led_status;
      logic [1:0] buzzer_level;
      logic       mute_latched;
      logic       reset_fire;
      logic [1:0] attempts_used;
   } watchdog_out_type;

   class watchdog_scoreboard;
      logic [31:0]      thresh [epw_pkg::NUM_REGS];
      bit               launched;
      logic [31:0]      last_pulse;
      bit               muted;
      int unsigned      attempts;
      watchdog_out_type expected_q [$];
      int unsigned      errors;
      int unsigned      responses;
      int unsigned      fires_seen;

      function new();
         thresh[epw_pkg::REG_PULSE_LOST]  = epw_pkg::RST_PULSE_LOST;
         thresh[epw_pkg::REG_SHORT_BEEP]  = epw_pkg::RST_SHORT_BEEP;
         thresh[epw_pkg::REG_LONG_BEEP]   = epw_pkg::RST_LONG_BEEP;
         thresh[epw_pkg::REG_CONTINUOUS]  = epw_pkg::RST_CONTINUOUS;
         thresh[epw_pkg::REG_RESET_ONE]   = epw_pkg::RST_RESET_ONE;
         thresh[epw_pkg::REG_RESET_TWO]   = epw_pkg::RST_RESET_TWO;
         thresh[epw_pkg::REG_RESET_THREE] = epw_pkg::RST_RESET_THREE;
         launched   = 1'b0;
         last_pulse = '0;
         muted      = 1'b0;
         attempts   = 0;
         errors     = 0;
         responses  = 0;
         fires_seen = 0;
      endfunction

      // drop writes to indexes past the register file
      function void write_reg(logic [epw_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
         if (idx < epw_pkg::NUM_REGS)
            thresh[idx] = data;
      endfunction

      function void note_request(logic [31:0] now_ms, logic pulse_seen, logic mute_press);
         watchdog_out_type want;
         logic [31:0]      elapsed;
         want = '0;
         want.led_status   = epw_pkg::LED_BOOT;
         want.buzzer_level = epw_pkg::BUZZ_SILENT;
         if (pulse_seen) begin
            last_pulse = now_ms;
            launched   = 1'b1;
            muted      = 1'b0;
            attempts   = 0;
         end
         if (mute_press)
            muted = 1'b1;
         if (launched) begin
            elapsed = now_ms - last_pulse;
            if (elapsed < thresh[epw_pkg::REG_PULSE_LOST]) begin
               want.led_status = epw_pkg::LED_OK;
            end else begin
               want.led_status = epw_pkg::LED_LOST;
               if (elapsed >= thresh[epw_pkg::REG_CONTINUOUS])
                  want.buzzer_level = epw_pkg::BUZZ_CONTINUOUS;
               else if (elapsed >= thresh[epw_pkg::REG_LONG_BEEP])
                  want.buzzer_level = epw_pkg::BUZZ_LONG;
               else if (elapsed >= thresh[epw_pkg::REG_SHORT_BEEP])
                  want.buzzer_level = epw_pkg::BUZZ_SHORT;
               if (attempts < ATTEMPT_LIMIT && attempts < epw_pkg::NUM_THRESH &&
                   elapsed >= thresh[epw_pkg::REG_RESET_ONE + attempts]) begin
                  attempts++;
                  want.reset_fire = 1'b1;
               end
            end
         end
         want.mute_latched  = muted;
         want.attempts_used = attempts[1:0];
         expected_q.push_back(want);
      endfunction

      function void fail_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(watchdog_out_type got);
         watchdog_out_type want;
         responses++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         if (want.reset_fire)
            fires_seen++;
         fail_field("led_status", want.led_status, got.led_status);
         fail_field("buzzer_level", want.buzzer_level, got.buzzer_level);
         fail_field("mute_latched", {1'b0, want.mute_latched}, {1'b0, got.mute_latched});
         fail_field("reset_fire", {1'b0, want.reset_fire}, {1'b0, got.reset_fire});
         fail_field("attempts_used", want.attempts_used, got.attempts_used);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: pulse watchdog regression
// Drives timestamped heartbeat requests through the watchdog under several
// threshold settings, with random stalls on both channels, and checks every
// response against a scoreboard that tracks pulse, mute and reset schedule.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int unsigned                     CYCLE_LIMIT  = 400000;
   localparam int unsigned                     DRAIN_CYCLES = 4;
   localparam int unsigned                     HOLD_CYCLES  = 300;
   localparam int unsigned                     HOLD_AFTER   = 300;
   localparam logic [epw_pkg::CSR_IDX_W-1:0]   REG_UNUSED   = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   epw_req_if req_if ();
   epw_rsp_if rsp_if ();
   epw_csr_if csr_if ();

   epw_scoreboard_pkg::watchdog_scoreboard sb = new();

   int unsigned cycle_count   = 0;
   int unsigned accepted      = 0;
   int unsigned settings_used = 0;
   logic [31:0] now_cursor    = '0;
   bit          no_idle       = 1'b0;
   bit          hold_done     = 1'b0;

   escalating_pulse_watchdog u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request; hold it until the watchdog takes it
   task automatic send_request(input logic [31:0] now_ms, input logic pulse_seen,
                               input logic mute_press);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid      = 1'b1;
      req_if.now_ms     = now_ms;
      req_if.pulse_seen = pulse_seen;
      req_if.mute_press = mute_press;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(now_ms, pulse_seen, mute_press);
      accepted++;
   endtask

   task automatic write_reg(input logic [epw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Drop valid, wait until every response is back, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [31:0] lost, input logic [31:0] short_beep,
                                 input logic [31:0] long_beep, input logic [31:0] cont,
                                 input logic [31:0] r1, input logic [31:0] r2,
                                 input logic [31:0] r3);
      write_reg(epw_pkg::REG_PULSE_LOST, lost);
      write_reg(epw_pkg::REG_SHORT_BEEP, short_beep);
      write_reg(epw_pkg::REG_LONG_BEEP, long_beep);
      write_reg(epw_pkg::REG_CONTINUOUS, cont);
      write_reg(epw_pkg::REG_RESET_ONE, r1);
      write_reg(epw_pkg::REG_RESET_TWO, r2);
      write_reg(epw_pkg::REG_RESET_THREE, r3);
      // out-of-range index must leave every threshold alone
      write_reg(REG_UNUSED, $urandom);
      settings_used++;
   endtask

   // Random heartbeat traffic: mostly time advancing in steps sized to the
   // thresholds, with pulses restarting the schedule, some mute presses and
   // occasional jumps anywhere on the 32-bit clock.
   task automatic run_random(input int unsigned count, input logic [31:0] scale,
                             input bit back_step);
      int unsigned roll;
      logic        pulse_seen;
      logic        mute_press;
      for (int unsigned i = 0; i < count; i++) begin
         roll       = $urandom_range(0, 99);
         pulse_seen = ($urandom_range(0, 99) < 9);
         mute_press = ($urandom_range(0, 99) < 10);
         if (roll < 5)
            now_cursor = $urandom;
         else if (roll < 10)
            now_cursor = now_cursor;
         else if (back_step && roll < 30)
            now_cursor = now_cursor + 32'hFFFF_FFFF;
         else
            now_cursor = now_cursor + $urandom_range(0, scale);
         send_request(now_cursor, pulse_seen, mute_press);
      end
   endtask

   // Response monitor: sample at the rising edge, check in order
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response({rsp_if.led_status, rsp_if.buzzer_level, rsp_if.mute_latched,
                            rsp_if.reset_fire, rsp_if.attempts_used});
   end

   // Response ready: random stalls, plus one long hold-off so the block
   // fills up and pushes back on requests
   initial begin
      int unsigned gap;
      int unsigned held;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && accepted >= HOLD_AFTER) begin
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               rsp_if.ready = 1'b0;
               held++;
            end
            hold_done = 1'b1;
         end else begin
            gap = pick_gap();
            repeat (gap) begin
               @(negedge clock);
               rsp_if.ready = 1'b0;
            end
            @(negedge clock);
            rsp_if.ready = 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] p;
      req_if.valid      = 1'b0;
      req_if.now_ms     = '0;
      req_if.pulse_seen = 1'b0;
      req_if.mute_press = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;

      // hold reset, then release it on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pass on the reset thresholds.
      // Booting: no pulse yet, mute still latches.
      send_request(32'h0000_0000, 1'b0, 1'b0);
      send_request(32'hFFFF_FFFF, 1'b0, 1'b1);
      // Pulse close to the top of the clock so the elapsed time wraps
      p = 32'hFFFF_FC00;
      send_request(p, 1'b1, 1'b0);
      send_request(p + 32'd1999, 1'b0, 1'b0);
      send_request(p + 32'd2000, 1'b0, 1'b0);
      send_request(p + 32'd59999, 1'b0, 1'b0);
      send_request(p + 32'd60000, 1'b0, 1'b0);
      send_request(p + 32'd120000, 1'b0, 1'b0);
      send_request(p + 32'd300000, 1'b0, 1'b0);
      // Walk the reset schedule, then run past its end
      send_request(p + 32'd599999, 1'b0, 1'b0);
      send_request(p + 32'd600000, 1'b0, 1'b0);
      send_request(p + 32'd600000, 1'b0, 1'b0);
      send_request(p + 32'd900000, 1'b0, 1'b0);
      send_request(p + 32'd1200000, 1'b0, 1'b0);
      send_request(p + 32'd4000000, 1'b0, 1'b0);
      // Mute while alarming, then pulse and mute on the same request
      send_request(p + 32'd4000000, 1'b0, 1'b1);
      send_request(32'h0000_0000, 1'b1, 1'b1);
      send_request(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_request(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'h7FFF_FFFF, 1'b0, 1'b1);
      now_cursor = 32'h7FFF_FFFF;
      run_random(100, 32'd90000, 1'b0);
      drain();

      // Small ordered thresholds, no idling on either side
      set_thresholds(32'd100, 32'd1000, 32'd2000, 32'd3000, 32'd5000, 32'd6000,
                     32'd7000);
      no_idle = 1'b1;
      run_random(120, 32'd1500, 1'b0);
      drain();
      no_idle = 1'b0;

      // All thresholds zero: always lost, continuous, fires at once
      set_thresholds('0, '0, '0, '0, '0, '0, '0);
      run_random(80, 32'd50, 1'b0);
      drain();

      // All thresholds at the top: only an elapsed of all ones reaches them
      set_thresholds('1, '1, '1, '1, '1, '1, '1);
      run_random(80, 32'hFFFF_FFFF, 1'b1);
      drain();

      // Unordered small thresholds
      set_thresholds($urandom_range(0, 8000), $urandom_range(0, 8000),
                     $urandom_range(0, 8000), $urandom_range(0, 8000),
                     $urandom_range(0, 8000), $urandom_range(0, 8000),
                     $urandom_range(0, 8000));
      run_random(120, 32'd2000, 1'b0);
      drain();

      // Full-range random thresholds and steps
      set_thresholds($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
      run_random(100, $urandom, 1'b0);
      drain();

      // Reset schedule in reverse order against ordered buzzer stages
      set_thresholds(32'd500, 32'd800, 32'd1600, 32'd3200, 32'd9000, 32'd6000,
                     32'd4000);
      run_random(130, 32'd2500, 1'b0);
      drain();

      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d responses still outstanding, expected 0", $time, sb.pending());
      end

      $display("Checked %0d responses to %0d requests over %0d written threshold sets,",
               sb.responses, accepted, settings_used);
      $display("with %0d forced reset strobes and %0d mismatches.", sb.fires_seen, sb.errors);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
